// ----- sv/lscc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_pkg: shared types and constants
// Character codes and the command item that passes from front to back.
// ----------------------------------------------------------------------------
package lscc_pkg;

  localparam int unsigned CharW = 16;

  localparam logic [CharW-1:0] ChSpace = 16'h0020;
  localparam logic [CharW-1:0] ChSlash = 16'h002F;
  localparam logic [CharW-1:0] ChBang  = 16'h0021;
  localparam logic [CharW-1:0] ChHash  = 16'h0023;

  // Result slots, emitted from the lowest set bit up
  localparam int unsigned SlotSpace = 0;
  localparam int unsigned SlotSl1   = 1;
  localparam int unsigned SlotSl2   = 2;
  localparam int unsigned SlotChar  = 3;
  localparam int unsigned SlotBare  = 4;
  localparam int unsigned SlotN     = 5;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [SlotN-1:0] mask;  // results still to send
    logic [CharW-1:0] ch;    // character for the char slot
    logic             eol;   // last result closes the line
  } cmd_t;

endpackage

// ----- sv/line_space_and_comment_cleaner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_space_and_comment_cleaner: text line cleaner
// Collapses and trims spaces and strips '//' and '#' comments from lines.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one 16-bit character per item, s_tlast marks the line's last one.
//   m_axis: cleaned characters; m_tuser=1 when m_tdata holds a character,
//     m_tuser=0 for a bare end-of-line marker; m_tlast closes each line.
//   An input item may cause zero to four results. The classifier decides
//   them on acceptance and queues one command (4 deep); the sequencer sends
//   one result per cycle from the head command while m_tready is high.
//   Path: a result passes through its queue entry, then the output register.
//   Throughput: one item per cycle while items yield at most one result and
//   m_tready is high; an item yielding several results sends them one per
//   cycle through the single output register, and the queue absorbs the rest.
//   Stall: when m_tready is low the output register holds, the queue fills,
//   and s_tready drops only once the queue is full.
//   Reset: asynchronous, active low; line state returns to line start and
//   the queue and output are emptied.
// ----------------------------------------------------------------------------
module line_space_and_comment_cleaner
  import lscc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CharW-1:0] s_tdata,   // [15:0] in_char
  input  logic             s_tlast,   // line_end
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [CharW-1:0] m_tdata,   // [15:0] out_char
  output logic             m_tuser,   // char_valid
  output logic             m_tlast    // end_of_line
);

  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;

  lscc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  lscc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_cmd),
    .pop_i   (pop),
    .dout_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lscc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

endmodule

// ----- sv/lscc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_front: input classifier
// Tracks line state and turns each character into a command of up to four
// results; commands that produce nothing are not queued.
// ----------------------------------------------------------------------------
module lscc_front
  import lscc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [CharW-1:0] s_tdata_i,   // [15:0] in_char
  input  logic             s_tlast_i,   // line_end
  input  logic             q_full_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o
);

  logic       at_start_q, at_start_d;
  logic       space_q, space_d;
  logic [1:0] held_q, held_d;
  logic       resolved_q, resolved_d;
  logic       cut_q, cut_d;
  logic [SlotN-1:0] mask;
  logic       accept;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && !q_full_i;

  // Classify the character against the held state
  always_comb begin
    logic [CharW-1:0] c;
    c          = s_tdata_i;
    mask       = '0;
    at_start_d = at_start_q;
    space_d    = space_q;
    held_d     = held_q;
    resolved_d = resolved_q;
    cut_d      = cut_q;

    if (!cut_q) begin
      if (held_q == 2'd2) begin
        if (c == ChBang) begin
          resolved_d           = 1'b1;
          held_d               = 2'd0;
          mask[SlotSpace]      = space_q;
          mask[SlotSl1]        = 1'b1;
          mask[SlotSl2]        = 1'b1;
          mask[SlotChar]       = 1'b1;
          space_d              = 1'b0;
        end else begin
          space_d = 1'b0;
          held_d  = 2'd0;
          cut_d   = 1'b1;
        end
      end else if (held_q == 2'd1) begin
        if (c == ChSlash) begin
          held_d = 2'd2;
        end else begin
          held_d          = 2'd0;
          mask[SlotSpace] = space_q;
          mask[SlotSl1]   = 1'b1;
          space_d         = 1'b0;
          if (c == ChSpace) begin
            space_d = 1'b1;
          end else if (c == ChHash) begin
            cut_d = 1'b1;
          end else begin
            mask[SlotChar] = 1'b1;
          end
        end
      end else begin
        if (c == ChSpace) begin
          if (!at_start_q) space_d = 1'b1;
        end else if (c == ChHash) begin
          space_d = 1'b0;
          cut_d   = 1'b1;
        end else if (c == ChSlash && !resolved_q) begin
          held_d = 2'd1;
        end else begin
          mask[SlotSpace] = space_q;
          mask[SlotChar]  = 1'b1;
          space_d         = 1'b0;
        end
      end
    end

    if (mask[SlotChar:SlotSpace] != '0) at_start_d = 1'b0;

    // Line end: a lone held slash goes out, an empty result becomes a bare marker, then state returns to reset
    if (s_tlast_i) begin
      if (!cut_d && held_d == 2'd1) begin
        mask[SlotSpace] = mask[SlotSpace] | space_d;
        mask[SlotSl1]   = 1'b1;
      end
      if (mask == '0) mask[SlotBare] = 1'b1;
      at_start_d = 1'b1;
      space_d    = 1'b0;
      held_d     = 2'd0;
      resolved_d = 1'b0;
      cut_d      = 1'b0;
    end
  end

  assign q_push_o     = accept && (mask != '0);
  assign q_cmd_o.mask = mask;
  assign q_cmd_o.ch   = s_tdata_i;
  assign q_cmd_o.eol  = s_tlast_i;

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      space_q    <= 1'b0;
      held_q     <= 2'd0;
      resolved_q <= 1'b0;
      cut_q      <= 1'b0;
    end else if (accept) begin
      at_start_q <= at_start_d;
      space_q    <= space_d;
      held_q     <= held_d;
      resolved_q <= resolved_d;
      cut_q      <= cut_d;
    end
  end

endmodule

// ----- sv/lscc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_fifo: command queue
// Small register queue between classifier and result sequencer.
// ----------------------------------------------------------------------------
module lscc_fifo
  import lscc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t din_i,
  input  logic pop_i,
  output cmd_t dout_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= din_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ----- sv/lscc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_back: result sequencer
// Walks the slots of the head command one result per cycle, while m_tready
// does not stall the output, into the output register.
// ----------------------------------------------------------------------------
module lscc_back
  import lscc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [CharW-1:0] m_tdata_o,   // [15:0] out_char
  output logic             m_tuser_o,   // char_valid
  output logic             m_tlast_o    // end_of_line
);

  logic             busy_q, busy_d;
  logic [SlotN-1:0] mask_q, mask_d;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_user_q, out_user_d;
  logic             out_last_q, out_last_d;
  logic [SlotN-1:0] cur_mask, low_bit, rem;
  logic             load, work;

  assign load     = !out_valid_q || m_tready_i;
  assign work     = busy_q || !empty_i;
  assign cur_mask = busy_q ? mask_q : head_i.mask;
  assign low_bit  = cur_mask & (~cur_mask + 1'b1);
  assign rem      = cur_mask & ~low_bit;
  assign pop_o    = load && work && (rem == '0);

  // Pick the next result of the head command
  always_comb begin
    busy_d     = busy_q;
    mask_d     = mask_q;
    out_char_d = head_i.ch;
    out_user_d = 1'b1;
    out_last_d = 1'b0;
    if (low_bit[SlotSpace]) begin
      out_char_d = ChSpace;
    end else if (low_bit[SlotSl1] || low_bit[SlotSl2]) begin
      out_char_d = ChSlash;
    end else if (low_bit[SlotBare]) begin
      out_char_d = '0;
      out_user_d = 1'b0;
    end
    if (load && work) begin
      if (rem == '0) begin
        busy_d     = 1'b0;
        out_last_d = head_i.eol;
      end else begin
        busy_d = 1'b1;
        mask_d = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mask_q <= mask_d;
      if (load) out_valid_q <= work;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load && work) begin
      out_char_q <= out_char_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_char_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

`ifndef SYNTH
  // A bare marker only ever closes a line
  a_bare_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> m_tlast_o)
    else $error("bare result without end of line");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> (m_tdata_o == '0))
    else $error("bare result carries a character");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  a_busy_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (mask_q != '0))
    else $error("sequencer busy with no slots left");
`endif

endmodule
